>>> sv/gdfw_pkg.sv
package gdfw_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_ENTRIES = 256;

    localparam int ID_W        = 6;
    localparam int STACK_SLOTS = 64;
    localparam int STACK_AW    = $clog2(STACK_SLOTS);
    localparam int DEPTH_W     = $clog2(STACK_SLOTS + 1);

    localparam logic [ID_W-1:0] RESULT_LIMIT = 6'd63;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_VISIT   = 2'd0;
    localparam logic [1:0] KIND_STORED  = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;
    localparam logic [1:0] KIND_CLEARED = 2'd3;

    typedef enum logic [1:0] {
        SRC_RES       = 2'd0,
        SRC_PEND_MID  = 2'd1,
        SRC_PEND_LAST = 2'd2
    } out_src_t;

    typedef struct packed {
        logic     take;
        logic     clear_graph;
        logic     app_a;
        logic     app_b;
        logic     app_swap;
        logic     walk_init;
        logic     head_load;
        logic     step_pop;
        logic     step_read;
        logic     pop_load;
        logic     check_adv;
        logic     out_load;
        out_src_t out_src;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic start_ok;
        logic depth_zero;
        logic depth_one;
        logic link_null;
        logic visit_ok;
        logic out_free;
    } sts_t;

endpackage

>>> sv/gdfw_dpath.sv
module gdfw_dpath
    import gdfw_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cmd_t            cmd,
    output sts_t            sts,
    input  logic [ID_W-1:0] node_a,
    input  logic [ID_W-1:0] node_b,
    input  logic [1:0]      operation,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [1:0]      kind,
    output logic [ID_W-1:0] node,
    output logic [ID_W-1:0] parent,
    output logic            last
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ENTRIES);

    logic [ID_W-1:0] nbr_mem  [MAX_ENTRIES];
    logic [LW-1:0]   next_mem [MAX_ENTRIES];
    logic [AW-1:0]   head_mem [MAX_NODES];
    logic [AW-1:0]   tail_mem [MAX_NODES];
    logic [ID_W+LW-1:0] stk_mem [STACK_SLOTS];

    logic [ID_W-1:0]    a_reg, b_reg;
    logic [1:0]         res_kind_reg;
    logic [LW-1:0]      used_reg, used_next;
    logic [MAX_NODES-1:0] head_valid_reg, head_valid_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [AW-1:0]      tail_rd_reg;
    logic               linked_reg;
    logic [AW-1:0]      head_rd_reg;
    logic [ID_W-1:0]    nbr_rd_reg;
    logic [LW-1:0]      next_rd_reg;
    logic [ID_W+LW-1:0] stk_rd_reg;
    logic [ID_W-1:0]    top_node_reg, top_node_next;
    logic [LW-1:0]      top_link_reg, top_link_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [ID_W-1:0]    count_reg, count_next;
    logic [ID_W-1:0]    pend_node_reg, pend_node_next;
    logic [ID_W-1:0]    pend_parent_reg, pend_parent_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [ID_W-1:0]    node_reg, node_next;
    logic [ID_W-1:0]    parent_reg, parent_next;
    logic               last_reg, last_next;

    logic [ID_W-1:0] owner, value;
    logic [NW-1:0]   owner_idx;
    logic [AW-1:0]   entry;
    logic            a_ok, b_ok;
    logic            push;
    logic [ID_W-1:0] push_id;
    logic [NW-1:0]   push_idx;
    logic            stk_write;
    logic            out_free;

    assign a_ok = (node_a != '0) && (32'(node_a) < MAX_NODES);
    assign b_ok = (node_b != '0) && (32'(node_b) < MAX_NODES);

    assign owner     = cmd.app_swap ? b_reg : a_reg;
    assign value     = cmd.app_swap ? a_reg : b_reg;
    assign owner_idx = NW'(owner);
    assign entry     = AW'(used_reg);

    assign push      = (cmd.walk_init && a_ok) || (cmd.check_adv && sts.visit_ok);
    assign push_id   = cmd.walk_init ? node_a : nbr_rd_reg;
    assign push_idx  = NW'(push_id);
    assign stk_write = cmd.check_adv && sts.visit_ok && (depth_reg != '0);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        sts.edge_ok    = a_ok && b_ok &&
                         (({1'b0, used_reg} + (LW+1)'(2)) <= (LW+1)'(MAX_ENTRIES));
        sts.start_ok   = a_ok;
        sts.depth_zero = (depth_reg == '0);
        sts.depth_one  = (depth_reg == DEPTH_W'(1));
        sts.link_null  = (top_link_reg == NULL_LINK);
        sts.visit_ok   = (32'(nbr_rd_reg) < MAX_NODES) && !visited_reg[NW'(nbr_rd_reg)] &&
                         (count_reg < RESULT_LIMIT);
        sts.out_free   = out_free;
    end

    always_comb
    begin
        used_next        = used_reg;
        head_valid_next  = head_valid_reg;
        visited_next     = visited_reg;
        top_node_next    = top_node_reg;
        top_link_next    = top_link_reg;
        depth_next       = depth_reg;
        count_next       = count_reg;
        pend_node_next   = pend_node_reg;
        pend_parent_next = pend_parent_reg;

        if (cmd.clear_graph)
        begin
            used_next       = '0;
            head_valid_next = '0;
        end
        if (cmd.app_a)
        begin
            head_valid_next[owner_idx] = 1'b1;
        end
        if (cmd.app_b)
        begin
            used_next = used_reg + LW'(1);
        end

        if (cmd.walk_init)
        begin
            visited_next     = '0;
            depth_next       = '0;
            count_next       = ID_W'(1);
            pend_node_next   = node_a;
            pend_parent_next = '0;
        end
        if (cmd.head_load)
        begin
            top_link_next = head_valid_reg[NW'(top_node_reg)] ? LW'(head_rd_reg) : NULL_LINK;
        end
        if (cmd.step_pop)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
        if (cmd.pop_load)
        begin
            top_node_next = stk_rd_reg[ID_W+LW-1:LW];
            top_link_next = stk_rd_reg[LW-1:0];
        end
        if (cmd.check_adv)
        begin
            top_link_next = next_rd_reg;
            if (sts.visit_ok)
            begin
                count_next       = count_reg + ID_W'(1);
                pend_node_next   = nbr_rd_reg;
                pend_parent_next = top_node_reg;
            end
        end
        if (push)
        begin
            visited_next[push_idx] = 1'b1;
            top_node_next          = push_id;
            depth_next             = (cmd.walk_init ? '0 : depth_reg) + DEPTH_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        kind_next      = kind_reg;
        node_next      = node_reg;
        parent_next    = parent_reg;
        last_next      = last_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
            case (cmd.out_src)
                SRC_PEND_MID:
                begin
                    kind_next   = KIND_VISIT;
                    node_next   = pend_node_reg;
                    parent_next = pend_parent_reg;
                    last_next   = 1'b0;
                end
                SRC_PEND_LAST:
                begin
                    kind_next   = KIND_VISIT;
                    node_next   = pend_node_reg;
                    parent_next = pend_parent_reg;
                    last_next   = 1'b1;
                end
                default:
                begin
                    kind_next   = res_kind_reg;
                    node_next   = '0;
                    parent_next = '0;
                    last_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            head_valid_reg <= head_valid_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_node_reg    <= top_node_next;
        top_link_reg    <= top_link_next;
        pend_node_reg   <= pend_node_next;
        pend_parent_reg <= pend_parent_next;
        kind_reg        <= kind_next;
        node_reg        <= node_next;
        parent_reg      <= parent_next;
        last_reg        <= last_next;
        if (cmd.take)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
            if (operation == OP_CLEAR)
            begin
                res_kind_reg <= KIND_CLEARED;
            end
            else
            begin
                res_kind_reg <= sts.edge_ok ? KIND_STORED : KIND_DROPPED;
            end
        end
        if (cmd.app_a)
        begin
            linked_reg <= head_valid_reg[owner_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_a)
        begin
            nbr_mem[entry] <= value;
        end
        if (cmd.step_read)
        begin
            nbr_rd_reg <= nbr_mem[AW'(top_link_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_a)
        begin
            next_mem[entry] <= NULL_LINK;
        end
        else if (cmd.app_b && linked_reg)
        begin
            next_mem[tail_rd_reg] <= used_reg;
        end
        if (cmd.step_read)
        begin
            next_rd_reg <= next_mem[AW'(top_link_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_a && !head_valid_reg[owner_idx])
        begin
            head_mem[owner_idx] <= entry;
        end
        if (push)
        begin
            head_rd_reg <= head_mem[push_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_a)
        begin
            tail_mem[owner_idx] <= entry;
            tail_rd_reg         <= tail_mem[owner_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_write)
        begin
            stk_mem[STACK_AW'(depth_reg - DEPTH_W'(1))] <= {top_node_reg, next_rd_reg};
        end
        if (cmd.step_pop)
        begin
            stk_rd_reg <= stk_mem[STACK_AW'(depth_reg - DEPTH_W'(2))];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign kind      = kind_reg;
    assign node      = node_reg;
    assign parent    = parent_reg;
    assign last      = last_reg;

endmodule

>>> sv/gdfw_ctrl.sv
module gdfw_ctrl
    import gdfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] operation,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_APA   = 11'b000_0000_0010,
        S_APB   = 11'b000_0000_0100,
        S_APA2  = 11'b000_0000_1000,
        S_APB2  = 11'b000_0001_0000,
        S_EMIT  = 11'b000_0010_0000,
        S_HEAD  = 11'b000_0100_0000,
        S_STEP  = 11'b000_1000_0000,
        S_POP   = 11'b001_0000_0000,
        S_CHECK = 11'b010_0000_0000,
        S_FLUSH = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_src = SRC_RES;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (operation)
                        OP_ADD:
                        begin
                            cmd.take   = 1'b1;
                            state_next = sts.edge_ok ? S_APA : S_EMIT;
                        end
                        OP_SEARCH:
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = sts.start_ok ? S_HEAD : S_IDLE;
                        end
                        OP_CLEAR:
                        begin
                            cmd.take        = 1'b1;
                            cmd.clear_graph = 1'b1;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APA:
            begin
                cmd.app_a  = 1'b1;
                state_next = S_APB;
            end
            S_APB:
            begin
                cmd.app_b  = 1'b1;
                state_next = S_APA2;
            end
            S_APA2:
            begin
                cmd.app_a    = 1'b1;
                cmd.app_swap = 1'b1;
                state_next   = S_APB2;
            end
            S_APB2:
            begin
                cmd.app_b    = 1'b1;
                cmd.app_swap = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_RES;
                    state_next   = S_IDLE;
                end
            end
            S_HEAD:
            begin
                cmd.head_load = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                if (sts.depth_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (sts.link_null)
                begin
                    cmd.step_pop = 1'b1;
                    state_next   = sts.depth_one ? S_STEP : S_POP;
                end
                else
                begin
                    cmd.step_read = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_STEP;
            end
            S_CHECK:
            begin
                if (!sts.visit_ok)
                begin
                    cmd.check_adv = 1'b1;
                    state_next    = S_STEP;
                end
                else if (sts.out_free)
                begin
                    cmd.check_adv = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_src   = SRC_PEND_MID;
                    state_next    = S_HEAD;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_PEND_LAST;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/graph_depth_first_walk.sv
// Undirected graph store with a depth-first walk, handling one request at a time.
// Adding an edge appends each endpoint to the other's neighbor list, and each list
// append reads the tail pointer memory before the link is written. In a search,
// each list entry scanned costs one read of the shared neighbor and link memories,
// each visited node one read of the list head memory, and each pop one read of
// the stack memory.
// Results leave through an output register, so a stalled result holds up the walk.
module graph_depth_first_walk
    import gdfw_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic [1:0]      operation,
    input  logic [ID_W-1:0] node_a,
    input  logic [ID_W-1:0] node_b,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [1:0]      kind,
    output logic [ID_W-1:0] node,
    output logic [ID_W-1:0] parent,
    output logic            last
);

    cmd_t cmd;
    sts_t sts;

    gdfw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    gdfw_dpath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .node_a    (node_a),
        .node_b    (node_b),
        .operation (operation),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .kind      (kind),
        .node      (node),
        .parent    (parent),
        .last      (last)
    );

endmodule

>>> bench/tb_graph_depth_first_walk.sv
`timescale 1ns / 100ps

module tb_graph_depth_first_walk;
    import gdfw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [8:0] NO_LINK = 9'(DEF_MAX_ENTRIES);
    localparam int REQUEST_TARGET = 380;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] node;
        logic [ID_W-1:0] parent;
        logic            last;
    } walk_result_t;

    typedef enum {FLOW_FREE, FLOW_TOGGLE, FLOW_COIN, FLOW_HEAVY} flow_t;

    class graph_walk_tracker;
        logic [ID_W-1:0] neighbour_of [DEF_MAX_ENTRIES];
        logic [8:0]      next_of [DEF_MAX_ENTRIES];
        logic [8:0]      head_of [DEF_MAX_NODES];
        logic [8:0]      tail_of [DEF_MAX_NODES];
        int              entries_taken;
        walk_result_t    awaited_results [$];
        int              mismatches;

        function new();
            mismatches = 0;
            empty_graph();
        endfunction

        function void empty_graph();
            foreach (head_of[i])
                head_of[i] = NO_LINK;
            entries_taken = 0;
        endfunction

        function void add_result(logic [1:0] k, logic [ID_W-1:0] n, logic [ID_W-1:0] p,
                                 logic l);
            walk_result_t item;
            item = '{k, n, p, l};
            awaited_results = {awaited_results, item};
        endfunction

        function void link_neighbour(logic [ID_W-1:0] owner, logic [ID_W-1:0] value);
            neighbour_of[entries_taken] = value;
            next_of[entries_taken] = NO_LINK;
            if (head_of[owner] == NO_LINK)
                head_of[owner] = 9'(entries_taken);
            else
                next_of[tail_of[owner]] = 9'(entries_taken);
            tail_of[owner] = 9'(entries_taken);
            entries_taken++;
        endfunction

        function void walk_from(logic [ID_W-1:0] start);
            bit              seen [DEF_MAX_NODES];
            logic [ID_W-1:0] stack_node [STACK_SLOTS];
            logic [8:0]      stack_link [STACK_SLOTS];
            int              depth;
            int              visits;
            logic [ID_W-1:0] here;
            logic [ID_W-1:0] next_node;
            logic [8:0]      link;
            if (start == '0)
                return;
            foreach (seen[i])
                seen[i] = 1'b0;
            seen[start] = 1'b1;
            add_result(KIND_VISIT, start, '0, 1'b0);
            visits = 1;
            stack_node[0] = start;
            stack_link[0] = head_of[start];
            depth = 1;
            while (depth > 0)
            begin
                here = stack_node[depth-1];
                link = stack_link[depth-1];
                if (link == NO_LINK)
                    depth--;
                else
                begin
                    next_node = neighbour_of[link];
                    stack_link[depth-1] = next_of[link];
                    if (!seen[next_node] && visits < RESULT_LIMIT)
                    begin
                        seen[next_node] = 1'b1;
                        add_result(KIND_VISIT, next_node, here, 1'b0);
                        visits++;
                        if (depth < STACK_SLOTS)
                        begin
                            stack_node[depth] = next_node;
                            stack_link[depth] = head_of[next_node];
                            depth++;
                        end
                    end
                end
            end
            awaited_results[awaited_results.size()-1].last = 1'b1;
        endfunction

        function int note_request(logic [1:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            int   size_then;
            logic ok;
            size_then = awaited_results.size();
            case (op)
                OP_ADD:
                begin
                    ok = (a != '0) && (b != '0) && (entries_taken + 2 <= DEF_MAX_ENTRIES);
                    if (ok)
                    begin
                        link_neighbour(a, b);
                        link_neighbour(b, a);
                    end
                    add_result(ok ? KIND_STORED : KIND_DROPPED, '0, '0, 1'b1);
                end
                OP_SEARCH:
                    walk_from(a);
                OP_CLEAR:
                begin
                    empty_graph();
                    add_result(KIND_CLEARED, '0, '0, 1'b1);
                end
                default:
                    ;
            endcase
            return awaited_results.size() - size_then;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task check_result(logic [1:0] got_kind, logic [ID_W-1:0] got_node,
                          logic [ID_W-1:0] got_parent, logic got_last);
            walk_result_t want;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d node %0d parent %0d last %0d",
                                          got_kind, got_node, got_parent, got_last));
                return;
            end
            want = awaited_results.pop_front();
            if (got_kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got_kind, want.kind));
            if (got_node !== want.node)
                report_mismatch($sformatf("node %0d, expected %0d", got_node, want.node));
            if (got_parent !== want.parent)
                report_mismatch($sformatf("parent %0d, expected %0d", got_parent, want.parent));
            if (got_last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d", got_last, want.last));
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    logic [1:0]      operation;
    logic [ID_W-1:0] node_a;
    logic [ID_W-1:0] node_b;
    logic            rsp_valid;
    logic            rsp_stall;
    logic [1:0]      kind;
    logic [ID_W-1:0] node;
    logic [ID_W-1:0] parent;
    logic            last;

    graph_walk_tracker sb;
    bit    valid_up;
    int    burst_left;
    int    items_done;
    int    stall_left;
    flow_t flow;

    graph_depth_first_walk DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .node_a    (node_a),
        .node_b    (node_b),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .kind      (kind),
        .node      (node),
        .parent    (parent),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(kind, node, parent, last);
            if (stall_left == 0)
            begin
                flow = flow_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 150);
            end
            else
                stall_left--;
            case (flow)
                FLOW_FREE:   rsp_stall <= 1'b0;
                FLOW_TOGGLE: rsp_stall <= ~rsp_stall;
                FLOW_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
                default:     rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic logic [ID_W-1:0] random_id();
        return ID_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [ID_W-1:0] pick_node(int hi);
        return ID_W'($urandom_range(hi, 1));
    endfunction

    task automatic lower_valid();
        if (valid_up)
        begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_request(logic [1:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        req_valid <= 1'b1;
        valid_up = 1'b1;
        operation <= op;
        node_a <= a;
        node_b <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (sb.note_request(op, a, b) > 0)
            items_done++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            lower_valid();
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 25)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain_results();
        lower_valid();
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic run_fill_phase();
        int hi;
        hi = $urandom_range(6, 20);
        send_request(OP_CLEAR, random_id(), random_id());
        for (int i = 0; i < 150; i++)
        begin
            if (i % 16 == 15)
                send_request(OP_SEARCH, pick_node(hi), random_id());
            else
                send_request(OP_ADD, pick_node(hi), pick_node(hi));
        end
        send_request(OP_SEARCH, pick_node(hi), random_id());
    endtask

    task automatic run_chain_phase();
        int order [63];
        int j;
        int keep;
        foreach (order[i])
            order[i] = i + 1;
        for (int i = 62; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            keep = order[i];
            order[i] = order[j];
            order[j] = keep;
        end
        send_request(OP_CLEAR, random_id(), random_id());
        for (int i = 0; i < 62; i++)
            send_request(OP_ADD, ID_W'(order[i]), ID_W'(order[i+1]));
        send_request(OP_SEARCH, ID_W'(order[0]), random_id());
        send_request(OP_SEARCH, ID_W'(order[31]), random_id());
    endtask

    task automatic run_mixed_phase();
        int hi;
        int pick;
        if ($urandom_range(0, 3) != 0)
            send_request(OP_CLEAR, random_id(), random_id());
        case ($urandom_range(0, 3))
            0:       hi = 4;
            1:       hi = 8;
            2:       hi = 16;
            default: hi = 63;
        endcase
        repeat ($urandom_range(5, 30))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_request(OP_ADD, pick_node(hi), pick_node(hi));
            else if (pick < 85)
                send_request(OP_SEARCH, pick_node(hi), random_id());
            else if (pick < 90)
                send_request(OP_UNUSED, random_id(), random_id());
            else if (pick < 95)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(OP_ADD, random_id(), '0);
                else
                    send_request(OP_ADD, '0, random_id());
            end
            else if (pick < 97)
                send_request(OP_SEARCH, '0, random_id());
            else
                send_request(OP_ADD, random_id(), random_id());
        end
        send_request(OP_SEARCH, pick_node(hi), random_id());
    endtask

    initial
    begin
        int phase;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        operation = OP_ADD;
        node_a = '0;
        node_b = '0;
        rsp_stall = 1'b0;
        valid_up = 1'b0;
        burst_left = 0;
        items_done = 0;
        stall_left = 0;
        flow = FLOW_FREE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_SEARCH, 6'd5, 6'd0);
        send_request(OP_ADD, 6'd1, 6'd63);
        send_request(OP_ADD, 6'd1, 6'd2);
        send_request(OP_ADD, 6'd2, 6'd3);
        send_request(OP_ADD, 6'd3, 6'd1);
        send_request(OP_ADD, 6'd63, 6'd62);
        send_request(OP_ADD, 6'd7, 6'd7);
        send_request(OP_ADD, 6'd0, 6'd5);
        send_request(OP_ADD, 6'd5, 6'd0);
        send_request(OP_ADD, 6'd0, 6'd0);
        send_request(OP_SEARCH, 6'd1, 6'd63);
        send_request(OP_SEARCH, 6'd63, 6'd0);
        send_request(OP_SEARCH, 6'd7, 6'd0);
        send_request(OP_SEARCH, 6'd0, 6'd0);
        send_request(OP_UNUSED, 6'd63, 6'd63);
        send_request(OP_SEARCH, 6'd42, 6'd21);
        send_request(OP_CLEAR, 6'd63, 6'd63);
        send_request(OP_SEARCH, 6'd1, 6'd0);
        send_request(OP_ADD, 6'd62, 6'd61);
        send_request(OP_SEARCH, 6'd62, 6'd0);
        drain_results();

        phase = 0;
        while (items_done < REQUEST_TARGET)
        begin
            if (phase == 0)
                run_fill_phase();
            else if (phase == 1)
                run_chain_phase();
            else
                run_mixed_phase();
            if (phase % 3 == 2)
                drain_results();
            phase++;
        end

        drain_results();
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_graph_depth_first_walk: PASS");
        else
            $display("tb_graph_depth_first_walk: FAIL");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("tb_graph_depth_first_walk: FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/gdfw_pkg.sv
sv/gdfw_dpath.sv
sv/gdfw_ctrl.sv
sv/graph_depth_first_walk.sv
bench/tb_graph_depth_first_walk.sv
